// ===== src/pfa_pkg.sv =====
// pfa_pkg: shared constants and codes for the page frame free-list allocator
// no dependencies; imported by page_frame_free_list_allocator
`default_nettype none

package pfa_pkg;

    localparam int PAGE_COUNT = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
    localparam int COUNT_W    = $clog2(PAGE_COUNT + 1);
    localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
    localparam int CFG_W      = 11;

    // command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_DBL_FREE  = 2'd2;
    localparam logic [1:0] ST_OUT_RANGE = 2'd3;

    // configuration register indexes
    localparam logic REG_FREE_LOW  = 1'b0;
    localparam logic REG_FREE_HIGH = 1'b1;

    localparam logic [CFG_W-1:0] FREE_LOW_RESET  = CFG_W'(256);
    localparam logic [CFG_W-1:0] FREE_HIGH_RESET = CFG_W'(1024);

endpackage : pfa_pkg

`default_nettype wire

// ===== src/page_frame_free_list_allocator.sv =====
// page_frame_free_list_allocator: lifo free list of page frames with in-use marks
// depends on pfa_pkg
// empty alloc, out-of-range free and the reserved command answer in the cycle after
//   the start transfer; alloc and free read the link/mark memory, then answer from
//   S_ALLOC or S_FREE, a memory read then write; no new command is taken while busy;
//   init walks every page frame
// reset: a clearing pass marks every page in use with busy high;
//   configuration transfers are taken meanwhile. the receiver cannot stall done
`default_nettype none

module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          cmd,
    input  wire logic [ADDR_W-1:0]   free_addr,
    // configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,
    // result strobe and payload
    output logic                     done,
    output logic [ADDR_W-1:0]        page_addr,
    output logic [1:0]               status
);

    // sequencer codes
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    localparam logic [PAGE_IDX_W-1:0] LAST_IDX   = PAGE_IDX_W'(PAGE_COUNT - 1);
    localparam logic [CFG_W-1:0]      CFG_LIMIT  = CFG_W'(PAGE_COUNT);

    // link and mark memories, one entry per page frame
    logic [PAGE_IDX_W-1:0] link_mem [PAGE_COUNT];
    logic                  use_mem  [PAGE_COUNT];

    logic [1:0]            state_reg,     state_next;
    logic [PAGE_IDX_W-1:0] idx_reg,       idx_next;
    logic                  clear_reg,     clear_next;
    logic [PAGE_IDX_W-1:0] head_reg,      head_next;
    logic [COUNT_W-1:0]    count_reg,     count_next;
    logic [PAGE_IDX_W-1:0] pg_reg,        pg_next;
    logic                  done_reg,      done_next;
    logic [1:0]            status_reg,    status_next;
    logic [ADDR_W-1:0]     page_addr_reg, page_addr_next;
    logic [CFG_W-1:0]      low_reg,       high_reg;

    logic [PAGE_IDX_W-1:0] link_rd_reg;
    logic                  use_rd_reg;

    // single write port per memory
    logic                  link_we;
    logic [PAGE_IDX_W-1:0] link_waddr, link_wdata;
    logic                  use_we;
    logic [PAGE_IDX_W-1:0] use_waddr;
    logic                  use_wdata;

    logic                  accept;
    logic [CFG_W-1:0]      lo_c, hi_c;
    logic [PFN_W-1:0]      free_pfn;
    logic                  free_in_range;
    logic                  sweep_in_range;
    logic [COUNT_W-1:0]    sweep_succ;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign done      = done_reg;
    assign page_addr = page_addr_reg;
    assign status    = status_reg;

    // bounds beyond the page count are clamped
    assign lo_c = (low_reg  > CFG_LIMIT) ? CFG_LIMIT : low_reg;
    assign hi_c = (high_reg > CFG_LIMIT) ? CFG_LIMIT : high_reg;

    // free range check on the full page frame number
    assign free_pfn      = free_addr[ADDR_W-1:PAGE_SHIFT];
    assign free_in_range = (free_pfn >= PFN_W'(lo_c)) && (free_pfn < PFN_W'(hi_c));

    // sweep: page idx_reg is free when inside [lo, hi), unless clearing after reset
    assign sweep_in_range = !clear_reg && (CFG_W'(idx_reg) >= lo_c)
                            && (CFG_W'(idx_reg) < hi_c);
    assign sweep_succ     = COUNT_W'(idx_reg) + COUNT_W'(1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= FREE_LOW_RESET;
            high_reg <= FREE_HIGH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FREE_LOW:  low_reg  <= cfg_data;
                REG_FREE_HIGH: high_reg <= cfg_data;
                default:       low_reg  <= low_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        clear_next     = clear_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pg_next        = pg_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        page_addr_next = page_addr_reg;
        link_we        = 1'b0;
        link_waddr     = idx_reg;
        link_wdata     = '0;
        use_we         = 1'b0;
        use_waddr      = idx_reg;
        use_wdata      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pg_next = free_addr[PAGE_SHIFT +: PAGE_IDX_W];
                    case (cmd)
                        CMD_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                // empty list, answer at once
                                done_next      = 1'b1;
                                status_next    = ST_NO_FREE;
                                page_addr_next = '0;
                            end
                            else
                            begin
                                state_next = S_ALLOC;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (!free_in_range)
                            begin
                                done_next      = 1'b1;
                                status_next    = ST_OUT_RANGE;
                                page_addr_next = '0;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        CMD_INIT:
                        begin
                            state_next = S_SWEEP;
                            idx_next   = '0;
                            clear_next = 1'b0;
                        end
                        default:
                        begin
                            // reserved command: no state change
                            done_next      = 1'b1;
                            status_next    = ST_OK;
                            page_addr_next = '0;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                use_we    = 1'b1;
                use_waddr = idx_reg;
                use_wdata = !sweep_in_range;
                if (sweep_in_range)
                begin
                    link_we    = 1'b1;
                    link_waddr = idx_reg;
                    link_wdata = (CFG_W'(sweep_succ) < hi_c)
                                 ? sweep_succ[PAGE_IDX_W-1:0] : '0;
                end
                idx_next = idx_reg + PAGE_IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                    if (!clear_reg && (lo_c < hi_c))
                    begin
                        head_next  = lo_c[PAGE_IDX_W-1:0];
                        count_next = COUNT_W'(hi_c - lo_c);
                    end
                    else
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    // the reset clearing pass gives no result
                    if (!clear_reg)
                    begin
                        done_next      = 1'b1;
                        status_next    = ST_OK;
                        page_addr_next = '0;
                    end
                    clear_next = 1'b0;
                end
            end
            S_ALLOC:
            begin
                // pop the head: link of the head was read in the start cycle
                use_we         = 1'b1;
                use_waddr      = head_reg;
                use_wdata      = 1'b1;
                head_next      = link_rd_reg;
                count_next     = count_reg - COUNT_W'(1);
                done_next      = 1'b1;
                status_next    = ST_OK;
                page_addr_next = ADDR_W'(head_reg) << PAGE_SHIFT;
                state_next     = S_IDLE;
            end
            S_FREE:
            begin
                done_next      = 1'b1;
                page_addr_next = '0;
                state_next     = S_IDLE;
                if (!use_rd_reg)
                begin
                    status_next = ST_DBL_FREE;
                end
                else
                begin
                    // push the page in front of the current head
                    status_next = ST_OK;
                    use_we      = 1'b1;
                    use_waddr   = pg_reg;
                    use_wdata   = 1'b0;
                    link_we     = 1'b1;
                    link_waddr  = pg_reg;
                    link_wdata  = head_reg;
                    head_next   = pg_reg;
                    count_next  = count_reg + COUNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            idx_reg       <= '0;
            clear_reg     <= 1'b1;
            head_reg      <= '0;
            count_reg     <= '0;
            pg_reg        <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            page_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            clear_reg     <= clear_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pg_reg        <= pg_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            page_addr_reg <= page_addr_next;
        end
    end

    // memories: registered reads, read in the start cycle and used in the cycle after
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (use_we)
        begin
            use_mem[use_waddr] <= use_wdata;
        end
        link_rd_reg <= link_mem[head_reg];
        use_rd_reg  <= use_mem[free_addr[PAGE_SHIFT +: PAGE_IDX_W]];
    end

    // the free count never exceeds the number of page frames
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(PAGE_COUNT))
        else $error("free count above page count");

    // an alloc on an empty list answers in the next cycle with no free page
    a_empty_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == CMD_ALLOC) && (count_reg == '0)
        |=> done && (status == ST_NO_FREE) && (page_addr == '0))
        else $error("empty alloc not reported");

    // only a successful alloc carries a page address
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_OK) |-> (page_addr == '0))
        else $error("page address on failed command");

    // a successful alloc takes one page off the list
    a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC) |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("alloc did not decrement free count");

endmodule : page_frame_free_list_allocator

`default_nettype wire
